FILE: design/alc_pkg.sv
// ============================================================================
// alc_pkg: shared types and codes of the array list with cursor
// Operation and status codes, and the packed transfer types of both channels.
// ============================================================================
package alc_pkg;

    // Operation codes carried in the kind field
    localparam logic [3:0] K_READ_CUR   = 4'd0;
    localparam logic [3:0] K_BACK       = 4'd1;
    localparam logic [3:0] K_FORWARD    = 4'd2;
    localparam logic [3:0] K_FIRST      = 4'd3;
    localparam logic [3:0] K_LAST       = 4'd4;
    localparam logic [3:0] K_DELETE     = 4'd5;
    localparam logic [3:0] K_INS_BEFORE = 4'd6;
    localparam logic [3:0] K_INS_AFTER  = 4'd7;
    localparam logic [3:0] K_READ_AT    = 4'd8;
    localparam logic [3:0] K_WRITE_AT   = 4'd9;

    // Status codes carried in the status field
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [5:0]  index;
    } t_in_item;

    typedef struct packed {
        logic [31:0] data;
        logic        moved;
        logic [1:0]  status;
        logic [6:0]  count;
    } t_out_item;

endpackage

FILE: design/array_list_with_cursor.sv
// ============================================================================
// array_list_with_cursor: ordered element list with a cursor
// Element memory with one write and one read port, worked by a small sequencer; one result per item.
// ============================================================================
// Each accepted item performs one list operation and returns one result. Cursor
// steps, first/last, write at, undefined kinds, out-of-range and empty/full
// errors complete straight from idle; read current and read at pass a read
// state. Delete and insert move one element at a time, a read state then a
// write state; delete shifts the elements behind the cursor down, insert
// shifts those from gap, the insert position, up. A new item is taken only
// while the sequencer is idle and the output register is empty or its result
// transfers out in that same cycle; a stalled result holds the input off.
module array_list_with_cursor #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  alc_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output alc_pkg::t_out_item o_out_data
);
    import alc_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);
    localparam int WW = (CW > 7) ? CW : 7;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SHRD = 5'b00100,
        S_SHWR = 5'b01000,
        S_PUT  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [PW-1:0]         r_cursor, n_cursor;
    logic [CW-1:0]         r_ptr, n_ptr;
    logic [CW-1:0]         r_gap, n_gap;
    logic                  r_up, n_up;
    logic                  r_bump, n_bump;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic                  r_ovalid, n_ovalid;
    t_out_item             r_out, n_out;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rd;
    logic                  mem_we, mem_re;
    logic [PW-1:0]         mem_wa, mem_ra;
    logic [DATA_WIDTH-1:0] mem_wd;

    logic                  out_free, in_fire, empty, full, in_range;
    logic [CW-1:0]         cur1, ptrm1;
    logic [WW-1:0]         idx_w;
    logic [63:0]           val64, rd64;

    // Truncate an element count to the result field
    function automatic logic [6:0] cnt_field(input logic [CW-1:0] c);
        logic [WW-1:0] w;
        w = WW'(c);
        return w[6:0];
    endfunction

    assign out_free    = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    assign empty    = (r_count == '0);
    assign full     = (r_count == CW'(CAPACITY));
    assign cur1     = CW'(r_cursor) + CW'(1);
    assign ptrm1    = r_ptr - CW'(1);
    assign idx_w    = WW'(i_in_data.index);
    assign in_range = idx_w < WW'(r_count);
    assign val64    = 64'(i_in_data.value);
    assign rd64     = 64'(r_rd);

    // Sequencer: decode, shift loop and result build
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_ptr    = r_ptr;
        n_gap    = r_gap;
        n_up     = r_up;
        n_bump   = r_bump;
        n_value  = r_value;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = '0;
        mem_re   = 1'b0;
        mem_ra   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_value = val64[DATA_WIDTH-1:0];
                    n_out   = '{data: '0, moved: 1'b0, status: ST_OK,
                                count: cnt_field(r_count)};
                    if (i_in_data.kind <= K_DELETE && empty) begin
                        n_out.status = ST_EMPTY;
                        n_ovalid     = 1'b1;
                    end else begin
                        unique case (i_in_data.kind) inside
                            K_READ_CUR: begin
                                mem_re  = 1'b1;
                                mem_ra  = r_cursor;
                                n_state = S_READ;
                            end
                            K_BACK: begin
                                if (r_cursor != '0) begin
                                    n_cursor    = r_cursor - PW'(1);
                                    n_out.moved = 1'b1;
                                end
                                n_ovalid = 1'b1;
                            end
                            K_FORWARD: begin
                                if (cur1 < r_count) begin
                                    n_cursor    = r_cursor + PW'(1);
                                    n_out.moved = 1'b1;
                                end
                                n_ovalid = 1'b1;
                            end
                            K_FIRST: begin
                                n_cursor = '0;
                                n_ovalid = 1'b1;
                            end
                            K_LAST: begin
                                n_ptr    = r_count - CW'(1);
                                n_cursor = n_ptr[PW-1:0];
                                n_ovalid = 1'b1;
                            end
                            K_DELETE: begin
                                n_ptr   = cur1;
                                n_up    = 1'b0;
                                n_state = S_SHRD;
                            end
                            K_INS_BEFORE, K_INS_AFTER: begin
                                if (full) begin
                                    n_out.status = ST_FULL;
                                    n_ovalid     = 1'b1;
                                end else begin
                                    n_up    = 1'b1;
                                    n_ptr   = r_count;
                                    n_bump  = !empty && (i_in_data.kind == K_INS_BEFORE);
                                    if (empty) begin
                                        n_gap = '0;
                                    end else if (i_in_data.kind == K_INS_BEFORE) begin
                                        n_gap = CW'(r_cursor);
                                    end else begin
                                        n_gap = cur1;
                                    end
                                    n_state = S_SHRD;
                                end
                            end
                            K_READ_AT: begin
                                if (in_range) begin
                                    mem_re  = 1'b1;
                                    mem_ra  = idx_w[PW-1:0];
                                    n_state = S_READ;
                                end else begin
                                    n_out.status = ST_RANGE;
                                    n_ovalid     = 1'b1;
                                end
                            end
                            K_WRITE_AT: begin
                                if (in_range) begin
                                    mem_we = 1'b1;
                                    mem_wa = idx_w[PW-1:0];
                                    mem_wd = val64[DATA_WIDTH-1:0];
                                end else begin
                                    n_out.status = ST_RANGE;
                                end
                                n_ovalid = 1'b1;
                            end
                            default: begin
                                n_ovalid = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                // Hold the fetched element until the output register frees
                if (out_free) begin
                    n_out.data = rd64[31:0];
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SHRD: begin
                if (!r_up) begin
                    if (r_ptr < r_count) begin
                        mem_re  = 1'b1;
                        mem_ra  = r_ptr[PW-1:0];
                        n_state = S_SHWR;
                    end else if (out_free) begin
                        // Close the gap done: drop the count, pull cursor back at tail
                        n_count = r_count - CW'(1);
                        if (cur1 == r_count && r_cursor != '0) begin
                            n_cursor = r_cursor - PW'(1);
                        end
                        n_out.count = cnt_field(n_count);
                        n_ovalid    = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    if (r_ptr > r_gap) begin
                        mem_re  = 1'b1;
                        mem_ra  = ptrm1[PW-1:0];
                        n_state = S_SHWR;
                    end else begin
                        n_state = S_PUT;
                    end
                end
            end
            S_SHWR: begin
                // Move one element across the gap and advance the pointer
                mem_we = 1'b1;
                mem_wd = r_rd;
                if (r_up) begin
                    mem_wa = r_ptr[PW-1:0];
                    n_ptr  = ptrm1;
                end else begin
                    mem_wa = ptrm1[PW-1:0];
                    n_ptr  = r_ptr + CW'(1);
                end
                n_state = S_SHRD;
            end
            S_PUT: begin
                mem_we = 1'b1;
                mem_wa = r_gap[PW-1:0];
                mem_wd = r_value;
                if (out_free) begin
                    n_count = r_count + CW'(1);
                    if (r_bump) begin
                        n_cursor = r_cursor + PW'(1);
                    end
                    n_out.count = cnt_field(n_count);
                    n_ovalid    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_gap   <= n_gap;
        r_up    <= n_up;
        r_bump  <= n_bump;
        r_value <= n_value;
        r_out   <= n_out;
    end

    // Element memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

endmodule

FILE: design/alc_checker.sv
// ============================================================================
// alc_checker: port-level checks of the array list with cursor
// Watches the top-level ports only; attached to the top level by bind.
// ============================================================================
module alc_checker #(
    parameter int CAPACITY = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input alc_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input alc_pkg::t_out_item o_out_data
);
    import alc_pkg::*;

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_out_valid) && !$past(i_out_ready)
            |-> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // An empty-list error always reports a zero count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_EMPTY |-> o_out_data.count == 7'd0)
        else $error("empty status with nonzero count");

    // A full-list error reports the capacity as count
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL
            |-> o_out_data.count == 7'(CAPACITY))
        else $error("full status with count below capacity");

    // A cursor move is only reported on a good step, with no data
    a_moved_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.moved
            |-> o_out_data.status == ST_OK && o_out_data.data == 32'd0)
        else $error("moved flag with error status or data");

    // After a transfer in, either a result is shown or the input is closed
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid || !o_in_ready)
        else $error("input open with no result after transfer");

endmodule

bind array_list_with_cursor alc_checker #(.CAPACITY(CAPACITY)) u_alc_checker (.*);
